// File: src/bos_pkg.sv
package bos_pkg;

   // Default store depth.
   localparam int DEF_MAX_BOXES = 256;

   // Field widths of the request and response words.
   localparam int OP_W        = 2;
   localparam int COORD_W     = 24;
   localparam int SIDE_W      = 20;
   localparam int FRAC_W      = 17;
   localparam int TOL_W       = 16;
   localparam int COUNT_OUT_W = 9;

   // Doubled-unit bounds: 2*center +/- side needs one bit more than 2*center.
   localparam int BOUND_W = COORD_W + 2;
   // Bounds with the edge tolerance added or taken off.
   localparam int EDGE_W  = BOUND_W + 2;
   // Width of an intersection span, at most twice the side length.
   localparam int SPAN_W  = SIDE_W + 2;
   localparam int PROD_W  = 2 * SPAN_W;
   // Square of the query side and the area limit derived from it.
   localparam int SQ_W     = 2 * SIDE_W;
   localparam int HALF_W   = SIDE_W;
   localparam int PART_W   = HALF_W + FRAC_W;
   localparam int SCALED_W = SQ_W + FRAC_W;
   // limit = (4 * side^2 * fraction) >> 16 = (side^2 * fraction) >> 14
   localparam int LIMIT_SHIFT = 14;
   localparam int LIMIT_W     = SCALED_W - LIMIT_SHIFT;

   typedef enum logic [OP_W-1:0] {
      OP_ADD         = 2'd0,
      OP_ANY_OVERLAP = 2'd1,
      OP_SIGNIFICANT = 2'd2
   } bos_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_query;
      logic write_box;
      logic scan_issue;
      logic load_result;
   } bos_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic store_empty;
      logic last_issue;
   } bos_status_type;

endpackage

// File: src/bos_req_if.sv
interface bos_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [bos_pkg::OP_W-1:0]      operation;
   logic signed [bos_pkg::COORD_W-1:0]   center_x;
   logic signed [bos_pkg::COORD_W-1:0]   center_y;
   logic        [bos_pkg::SIDE_W-1:0]    side_length;
   logic        [bos_pkg::FRAC_W-1:0]    area_fraction;

   modport source (
      output valid, operation, center_x, center_y, side_length, area_fraction,
      input  ready
   );

   modport sink (
      input  valid, operation, center_x, center_y, side_length, area_fraction,
      output ready
   );
endinterface

// File: src/bos_rsp_if.sv
interface bos_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic                                rejected;
   logic [bos_pkg::COUNT_OUT_W-1:0]     stored_count;

   modport source (
      output valid, hit, rejected, stored_count,
      input  ready
   );

   modport sink (
      input  valid, hit, rejected, stored_count,
      output ready
   );
endinterface

// File: src/bos_ctrl.sv
module bos_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [bos_pkg::OP_W-1:0]  req_operation,
   output logic                      req_ready,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   input  bos_pkg::bos_status_type   status,
   output bos_pkg::bos_cmd_type      cmd
);

   // Cycles for the last read to pass the read register, the span stage,
   // the product stage and the accumulator.
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type            state_ff;
   logic [DRAIN_W-1:0]   drain_ff;
   logic                 rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.load_query  = (state_ff == S_IDLE) && req_valid;
      cmd.write_box   = (state_ff == S_ADD);
      cmd.scan_issue  = (state_ff == S_SCAN);
      cmd.load_result = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               drain_ff <= '0;
               if (req_valid) begin
                  case (req_operation)
                     bos_pkg::OP_ADD: begin
                        state_ff <= S_ADD;
                     end
                     bos_pkg::OP_ANY_OVERLAP, bos_pkg::OP_SIGNIFICANT: begin
                        state_ff <= status.store_empty ? S_DRAIN : S_SCAN;
                     end
                     default: begin
                        state_ff <= S_FINISH;
                     end
                  endcase
               end
            end
            S_ADD: begin
               state_ff <= S_FINISH;
            end
            S_SCAN: begin
               if (status.last_issue) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.load_result) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: src/bos_datapath.sv
module bos_datapath #(
   parameter int MAX_BOXES = bos_pkg::DEF_MAX_BOXES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic        [bos_pkg::TOL_W-1:0]     csr_write_data,
   input  logic        [bos_pkg::OP_W-1:0]      req_operation,
   input  logic signed [bos_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [bos_pkg::COORD_W-1:0]   req_center_y,
   input  logic        [bos_pkg::SIDE_W-1:0]    req_side_length,
   input  logic        [bos_pkg::FRAC_W-1:0]    req_area_fraction,
   output logic                                 rsp_hit,
   output logic                                 rsp_rejected,
   output logic        [bos_pkg::COUNT_OUT_W-1:0] rsp_stored_count,
   input  bos_pkg::bos_cmd_type                 cmd,
   output bos_pkg::bos_status_type              status
);

   localparam int CW      = $clog2(MAX_BOXES + 1);
   localparam int AW      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BW      = bos_pkg::BOUND_W;
   localparam int EW      = bos_pkg::EDGE_W;
   localparam int SW      = bos_pkg::SPAN_W;
   localparam int ENTRY_W = 4 * BW;
   localparam int TOTAL_W = bos_pkg::PROD_W + CW;
   localparam int OUT_W   = bos_pkg::COUNT_OUT_W;

   // Box store: {x_lo, x_hi, y_lo, y_hi} in doubled units.
   logic [ENTRY_W-1:0]  mem [MAX_BOXES];
   logic [ENTRY_W-1:0]  rd_ff;
   logic                rd_valid_ff;

   logic [bos_pkg::TOL_W-1:0]  tol_ff;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              addr_ff;
   logic [CW-1:0]              addr_next;
   logic                       full;

   // Query held for the whole item.
   logic        [bos_pkg::OP_W-1:0]    q_op_ff;
   logic signed [BW-1:0]               qxl_ff, qxh_ff, qyl_ff, qyh_ff;
   logic signed [BW-1:0]               qxl_in, qxh_in, qyl_in, qyh_in;
   logic signed [BW-1:0]               cx2, cy2, side_ext;
   logic        [bos_pkg::SIDE_W-1:0]  q_side_ff;
   logic        [bos_pkg::FRAC_W-1:0]  q_frac_ff;
   logic                               rej_ff;

   // Area limit pipeline.
   logic [bos_pkg::SQ_W-1:0]      sq_ff;
   logic [bos_pkg::PART_W-1:0]    part_lo_ff, part_hi_ff;
   logic [bos_pkg::SCALED_W-1:0]  scaled;
   logic [bos_pkg::LIMIT_W-1:0]   limit_ff;

   // Span stage.
   logic signed [BW-1:0]  bxl, bxh, byl, byh;
   logic signed [EW-1:0]  qxl_e, qxh_e, qyl_e, qyh_e;
   logic signed [EW-1:0]  bxl_e, bxh_e, byl_e, byh_e, eps_e;
   logic signed [EW-1:0]  span_w, span_h;
   logic                  overlap;
   logic                  s2_valid_ff, s2_overlap_ff, s2_pos_ff;
   logic [SW-1:0]         s2_w_ff, s2_h_ff;

   // Product and accumulator stages.
   logic                          s3_valid_ff;
   logic [bos_pkg::PROD_W-1:0]    prod_ff;
   logic [TOTAL_W-1:0]            total_ff;
   logic                          hit_any_ff;
   logic                          sig_hit;

   logic [CW+OUT_W-1:0]  count_wide;
   logic                 hit_out_ff, rej_out_ff;
   logic [OUT_W-1:0]     count_out_ff;

   assign full      = (count_ff == CW'(MAX_BOXES));
   assign addr_next = addr_ff + 1'b1;

   assign status.store_empty = (count_ff == '0);
   assign status.last_issue  = (addr_next == count_ff);

   // Bounds of the incoming box at twice the coordinate resolution.
   assign cx2      = {{(BW - bos_pkg::COORD_W - 1){req_center_x[bos_pkg::COORD_W-1]}},
                      req_center_x, 1'b0};
   assign cy2      = {{(BW - bos_pkg::COORD_W - 1){req_center_y[bos_pkg::COORD_W-1]}},
                      req_center_y, 1'b0};
   assign side_ext = {{(BW - bos_pkg::SIDE_W){1'b0}}, req_side_length};
   assign qxl_in   = cx2 - side_ext;
   assign qxh_in   = cx2 + side_ext;
   assign qyl_in   = cy2 - side_ext;
   assign qyh_in   = cy2 + side_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         if (cmd.write_box && !full) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_box && !full) begin
         mem[count_ff[AW-1:0]] <= {qxl_ff, qxh_ff, qyl_ff, qyh_ff};
      end
      if (cmd.scan_issue) begin
         rd_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_op_ff   <= req_operation;
         qxl_ff    <= qxl_in;
         qxh_ff    <= qxh_in;
         qyl_ff    <= qyl_in;
         qyh_ff    <= qyh_in;
         q_side_ff <= req_side_length;
         q_frac_ff <= req_area_fraction;
      end
      if (cmd.load_query) begin
         rej_ff <= 1'b0;
      end else if (cmd.write_box) begin
         rej_ff <= full;
      end
   end

   // Limit: (side^2 * fraction) >> 14, with side^2 split into two halves.
   assign scaled = (bos_pkg::SCALED_W'(part_hi_ff) << bos_pkg::HALF_W)
                 + bos_pkg::SCALED_W'(part_lo_ff);

   always_ff @(posedge clock) begin
      sq_ff      <= q_side_ff * q_side_ff;
      part_lo_ff <= sq_ff[bos_pkg::HALF_W-1:0] * q_frac_ff;
      part_hi_ff <= sq_ff[bos_pkg::SQ_W-1:bos_pkg::HALF_W] * q_frac_ff;
      limit_ff   <= scaled[bos_pkg::SCALED_W-1:bos_pkg::LIMIT_SHIFT];
   end

   // Span stage: edge test and intersection widths for one stored box.
   assign bxl = rd_ff[4*BW-1:3*BW];
   assign bxh = rd_ff[3*BW-1:2*BW];
   assign byl = rd_ff[2*BW-1:BW];
   assign byh = rd_ff[BW-1:0];

   assign qxl_e = {{(EW - BW){qxl_ff[BW-1]}}, qxl_ff};
   assign qxh_e = {{(EW - BW){qxh_ff[BW-1]}}, qxh_ff};
   assign qyl_e = {{(EW - BW){qyl_ff[BW-1]}}, qyl_ff};
   assign qyh_e = {{(EW - BW){qyh_ff[BW-1]}}, qyh_ff};
   assign bxl_e = {{(EW - BW){bxl[BW-1]}}, bxl};
   assign bxh_e = {{(EW - BW){bxh[BW-1]}}, bxh};
   assign byl_e = {{(EW - BW){byl[BW-1]}}, byl};
   assign byh_e = {{(EW - BW){byh[BW-1]}}, byh};
   assign eps_e = {{(EW - bos_pkg::TOL_W - 1){1'b0}}, tol_ff, 1'b0};

   assign overlap = !((qxh_e < bxl_e + eps_e) || (qxl_e > bxh_e - eps_e) ||
                      (qyh_e < byl_e + eps_e) || (qyl_e > byh_e - eps_e));

   assign span_w = ((qxh_e < bxh_e) ? qxh_e : bxh_e) - ((qxl_e > bxl_e) ? qxl_e : bxl_e);
   assign span_h = ((qyh_e < byh_e) ? qyh_e : byh_e) - ((qyl_e > byl_e) ? qyl_e : byl_e);

   always_ff @(posedge clock) begin
      s2_overlap_ff <= overlap;
      s2_pos_ff     <= !span_w[EW-1] && (span_w != '0) && !span_h[EW-1] && (span_h != '0);
      s2_w_ff       <= span_w[SW-1:0];
      s2_h_ff       <= span_h[SW-1:0];
      if (s2_overlap_ff && s2_pos_ff) begin
         prod_ff <= s2_w_ff * s2_h_ff;
      end else begin
         prod_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         total_ff    <= '0;
         hit_any_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         s2_valid_ff <= rd_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.load_query) begin
            addr_ff    <= '0;
            total_ff   <= '0;
            hit_any_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               addr_ff <= addr_next;
            end
            if (s2_valid_ff && s2_overlap_ff) begin
               hit_any_ff <= 1'b1;
            end
            if (s3_valid_ff) begin
               total_ff <= total_ff + TOTAL_W'(prod_ff);
            end
         end
      end
   end

   assign sig_hit    = (total_ff > TOTAL_W'(limit_ff));
   assign count_wide = {{OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         case (q_op_ff)
            bos_pkg::OP_ANY_OVERLAP: hit_out_ff <= hit_any_ff;
            bos_pkg::OP_SIGNIFICANT: hit_out_ff <= sig_hit;
            default:                 hit_out_ff <= 1'b0;
         endcase
         rej_out_ff   <= rej_ff;
         count_out_ff <= count_wide[OUT_W-1:0];
      end
   end

   assign rsp_hit          = hit_out_ff;
   assign rsp_rejected     = rej_out_ff;
   assign rsp_stored_count = count_out_ff;

endmodule

// File: src/box_overlap_store.sv
// Box overlap store: holds up to MAX_BOXES square boxes and answers overlap
// queries against them. Each request word on req_chan carries an operation,
// a centre, a side length and an area fraction; each request yields exactly
// one response word on rsp_chan with the hit and rejected flags and the
// number of boxes held afterwards. The edge tolerance must be written through
// csr_write_enable and csr_write_data only while the block is idle; the block
// itself does not enforce this. A query reads the box memory one entry per
// cycle through a single read port, then waits for the read, span, product
// and accumulate stages to empty.
// Requests are taken one at a time; req_chan.ready is high only while the
// controller waits for a new word.
// The response sits in an output register, so the next request is accepted
// while an earlier response still waits; if the receiver stalls, the finished
// item is held in the controller until the output register frees up.
// A synchronous reset empties the store and clears the tolerance to zero;
// box memory contents are not cleared, since only entries below the count
// are ever read.
module box_overlap_store #(
   parameter int MAX_BOXES = bos_pkg::DEF_MAX_BOXES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [bos_pkg::TOL_W-1:0]    csr_write_data,
   bos_req_if.sink                      req_chan,
   bos_rsp_if.source                    rsp_chan
);

   bos_pkg::bos_cmd_type     cmd;
   bos_pkg::bos_status_type  status;
   logic                     req_ready;
   logic                     rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // The controller sequences add, scan, drain and result hand-over.
   bos_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_valid),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the store, the query, the scan pipeline and the
   // response register.
   bos_datapath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_operation     (req_chan.operation),
      .req_center_x      (req_chan.center_x),
      .req_center_y      (req_chan.center_y),
      .req_side_length   (req_chan.side_length),
      .req_area_fraction (req_chan.area_fraction),
      .rsp_hit           (rsp_chan.hit),
      .rsp_rejected      (rsp_chan.rejected),
      .rsp_stored_count  (rsp_chan.stored_count),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Testbench for box_overlap_store.
//
// Request words go in on a valid/ready channel and every accepted word causes
// exactly one response word. A predictor in this module keeps its own copy of
// the box store, the box count and the edge tolerance. It works out the
// response for each request word at the edge where the word is accepted and
// queues it. The response monitor compares each accepted response word, field
// by field, with the oldest queued expectation.
//
// The run starts with a short directed table covering the empty store, the
// corner boxes, zero sides, fractions of zero, one and above one, edge
// contact and the unused operation code. Where a row's response is obvious,
// it is typed into the table. The other rows are checked against the
// predictor. Eight random phases follow, each with its own tolerance. The
// tolerance register is only written once every expected response has come
// back. Coordinates are mostly clustered so that boxes really do overlap, and
// enough boxes are added over the run to fill the store and get adds refused.
module testbench;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_BOXES    = bos_pkg::DEF_MAX_BOXES;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 100;
   // A long hold-off on the response side, so that the block fills up.
   localparam int HOLD_OFF_CYCLES = 2500;
   // A full-store query must be able to finish within this wait, with room to spare.
   localparam int SETTLE_CYCLES = MAX_BOXES + 16;
   localparam int DRAIN_LIMIT   = 200000;
   // The watchdog is set well beyond the slowest correct run.
   localparam longint WATCHDOG_NS = 20_000_000;

   // The request field is two bits wide, but the package names only three codes.
   localparam logic [bos_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [bos_pkg::COORD_W-1:0] COORD_TOP    = 24'h7FFFFF;
   localparam logic [bos_pkg::COORD_W-1:0] COORD_BOTTOM = 24'h800000;
   localparam logic [bos_pkg::SIDE_W-1:0]  SIDE_MAX     = '1;
   localparam logic [bos_pkg::FRAC_W-1:0]  FRAC_ONE     = 17'h10000;
   localparam logic [bos_pkg::FRAC_W-1:0]  FRAC_MAX     = '1;

   // Table rows either carry a response typed in by hand or use the predictor.
   localparam bit KNOWN     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef longint unsigned area_type;

   typedef struct {
      logic        [bos_pkg::OP_W-1:0]    op;
      logic signed [bos_pkg::COORD_W-1:0] center_x;
      logic signed [bos_pkg::COORD_W-1:0] center_y;
      logic        [bos_pkg::SIDE_W-1:0]  side;
      logic        [bos_pkg::FRAC_W-1:0]  frac;
   } box_request_type;

   typedef struct packed {
      logic                            hit;
      logic                            rejected;
      logic [bos_pkg::COUNT_OUT_W-1:0] stored_count;
   } box_reply_type;

   typedef struct {
      box_request_type word;
      bit              typed;
      box_reply_type   reply;
   } directed_row_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [bos_pkg::TOL_W-1:0]    csr_write_data;

   bos_req_if req_bus ();
   bos_rsp_if rsp_bus ();

   box_overlap_store uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   // This is the predictor's own view of the block. Bounds are held in doubled
   // units, just as the block holds them.
   logic signed [bos_pkg::BOUND_W-1:0] box_x_lo [MAX_BOXES];
   logic signed [bos_pkg::BOUND_W-1:0] box_x_hi [MAX_BOXES];
   logic signed [bos_pkg::BOUND_W-1:0] box_y_lo [MAX_BOXES];
   logic signed [bos_pkg::BOUND_W-1:0] box_y_hi [MAX_BOXES];
   int                                 held_boxes    = 0;
   logic [bos_pkg::TOL_W-1:0]          tolerance_now = '0;

   box_reply_type    expected_replies [$];
   directed_row_type directed_rows [$];
   int               failures         = 0;
   bit               steady_flow      = 1'b0;
   bit               hold_off_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("testbench failed");
      $finish;
   end

   // This function applies one accepted request word to the predicted state
   // and returns the response that the word should cause.
   function automatic box_reply_type predict_box_reply(input box_request_type w);
      box_reply_type reply;
      longint        qx_lo, qx_hi, qy_lo, qy_hi, margin, span_w, span_h;
      area_type      overlap_sum, query_area4, area_limit;
      reply.hit = 1'b0;
      reply.rejected = 1'b0;
      qx_lo = 2 * longint'(w.center_x) - longint'(w.side);
      qx_hi = 2 * longint'(w.center_x) + longint'(w.side);
      qy_lo = 2 * longint'(w.center_y) - longint'(w.side);
      qy_hi = 2 * longint'(w.center_y) + longint'(w.side);
      margin = 2 * longint'(tolerance_now);
      overlap_sum = 0;
      if (w.op == bos_pkg::OP_ADD) begin
         if (held_boxes >= MAX_BOXES) begin
            // The store is full, so the box is refused and nothing changes.
            reply.rejected = 1'b1;
         end else begin
            box_x_lo[held_boxes] = bos_pkg::BOUND_W'(qx_lo);
            box_x_hi[held_boxes] = bos_pkg::BOUND_W'(qx_hi);
            box_y_lo[held_boxes] = bos_pkg::BOUND_W'(qy_lo);
            box_y_hi[held_boxes] = bos_pkg::BOUND_W'(qy_hi);
            held_boxes++;
         end
      end else if (w.op == bos_pkg::OP_ANY_OVERLAP || w.op == bos_pkg::OP_SIGNIFICANT) begin
         for (int i = 0; i < held_boxes; i++) begin
            // Contact within the tolerance margin does not count as overlap.
            if (qx_hi < box_x_lo[i] + margin || qx_lo > box_x_hi[i] - margin ||
                qy_hi < box_y_lo[i] + margin || qy_lo > box_y_hi[i] - margin)
               continue;
            if (w.op == bos_pkg::OP_ANY_OVERLAP) begin
               reply.hit = 1'b1;
               break;
            end
            span_w = ((qx_hi < box_x_hi[i]) ? qx_hi : box_x_hi[i]) -
                     ((qx_lo > box_x_lo[i]) ? qx_lo : box_x_lo[i]);
            span_h = ((qy_hi < box_y_hi[i]) ? qy_hi : box_y_hi[i]) -
                     ((qy_lo > box_y_lo[i]) ? qy_lo : box_y_lo[i]);
            if (span_w > 0 && span_h > 0)
               overlap_sum += area_type'(span_w) * area_type'(span_h);
         end
         if (w.op == bos_pkg::OP_SIGNIFICANT) begin
            // Both sides of the comparison are four times the true area.
            query_area4 = 4 * area_type'(w.side) * area_type'(w.side);
            area_limit = (query_area4 * w.frac) >> 16;
            reply.hit = (overlap_sum > area_limit);
         end
      end
      reply.stored_count = bos_pkg::COUNT_OUT_W'(held_boxes);
      return reply;
   endfunction

   function automatic int unsigned pick_idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return $urandom_range(1, 3);
      else if (roll < 92)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   // Most coordinates fall near the origin or near the two corners, where the
   // directed boxes lie. The rest cover the whole signed range.
   function automatic logic [bos_pkg::COORD_W-1:0] pick_coord();
      logic [bos_pkg::COORD_W-1:0] value;
      case ($urandom_range(0, 9))
         0, 1:    value = bos_pkg::COORD_W'($urandom);
         2:       value = COORD_TOP - bos_pkg::COORD_W'($urandom_range(0, 'h3000));
         3:       value = COORD_BOTTOM + bos_pkg::COORD_W'($urandom_range(0, 'h3000));
         default: value = bos_pkg::COORD_W'($urandom_range(0, 'h6000) - 'h3000);
      endcase
      return value;
   endfunction

   function automatic void put_row(input logic [bos_pkg::OP_W-1:0] op,
                                   input logic [bos_pkg::COORD_W-1:0] cx,
                                   input logic [bos_pkg::COORD_W-1:0] cy,
                                   input logic [bos_pkg::SIDE_W-1:0] side,
                                   input logic [bos_pkg::FRAC_W-1:0] frac,
                                   input bit typed, input logic hit,
                                   input logic rejected,
                                   input logic [bos_pkg::COUNT_OUT_W-1:0] count);
      directed_row_type row;
      row.word.op = op;
      row.word.center_x = cx;
      row.word.center_y = cy;
      row.word.side = side;
      row.word.frac = frac;
      row.typed = typed;
      row.reply.hit = hit;
      row.reply.rejected = rejected;
      row.reply.stored_count = count;
      directed_rows.push_back(row);
   endfunction

   // This task offers one request word, sometimes after an idle gap, and waits
   // until the word is accepted. The task is called at a rising edge. When no
   // gap is wanted, valid stays high from the word before, so it is never
   // lowered and raised again in the same step.
   task automatic offer_word(input box_request_type w, input bit typed,
                             input box_reply_type typed_reply);
      box_reply_type predicted;
      int unsigned   gap;
      gap = 0;
      if (!steady_flow && $urandom_range(0, 99) < 45)
         gap = pick_idle_cycles();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= w.op;
      req_bus.center_x      <= w.center_x;
      req_bus.center_y      <= w.center_y;
      req_bus.side_length   <= w.side;
      req_bus.area_fraction <= w.frac;
      do @(posedge clock); while (!req_bus.ready);
      // The word was accepted at this edge. The predictor still runs for rows
      // with a typed response, because an add must update the store.
      predicted = predict_box_reply(w);
      expected_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // This process is the response side. Ready is driven once per edge. Short
   // random stalls are mixed with a long hold-off whenever one is requested.
   initial begin : reply_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 25)
               stall_left = pick_idle_cycles();
         end
      end
   end

   // This block checks each response word against the oldest expectation. It
   // samples at the edge, so it sees the values from before the edge.
   always @(posedge clock) begin : reply_check
      box_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: response word with nothing expected (hit %0b rejected %0b count %0d)",
                     $time, rsp_bus.hit, rsp_bus.rejected, rsp_bus.stored_count);
            failures++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $display("%0t: hit expected %0b, got %0b", $time, want.hit, rsp_bus.hit);
               failures++;
            end
            if (rsp_bus.rejected !== want.rejected) begin
               $display("%0t: rejected expected %0b, got %0b",
                        $time, want.rejected, rsp_bus.rejected);
               failures++;
            end
            if (rsp_bus.stored_count !== want.stored_count) begin
               $display("%0t: stored_count expected %0d, got %0d",
                        $time, want.stored_count, rsp_bus.stored_count);
               failures++;
            end
         end
      end
   end

   initial begin : stimulus
      box_request_type           word;
      box_reply_type             no_reply;
      int unsigned               counted;
      int unsigned               drain;
      int unsigned               roll;
      logic [bos_pkg::TOL_W-1:0] phase_tolerance [PHASES];
      int unsigned               add_pct [PHASES];

      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_write_data        <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= bos_pkg::OP_ADD;
      req_bus.center_x      <= '0;
      req_bus.center_y      <= '0;
      req_bus.side_length   <= '0;
      req_bus.area_fraction <= '0;
      no_reply = '0;

      // The tolerance differs from phase to phase and includes both extremes.
      // Adds are frequent enough in the middle phases that the store fills
      // up, so the later phases see both refused adds and full-length scans.
      phase_tolerance = '{16'h0000, 16'hFFFF, 16'h0010, 16'h0000,
                          16'h0001, 16'h0000, 16'h0200, 16'h0080};
      phase_tolerance[3] = bos_pkg::TOL_W'($urandom_range(2, 16'hFFFE));
      add_pct = '{50, 30, 40, 50, 50, 60, 20, 40};

      // The directed table runs with the tolerance at its reset value of zero.
      // The store is empty for the first rows, so every query must miss.
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'h000000, 24'h000000, 20'h00100, 17'h00000,
              KNOWN, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, 24'h000000, 24'h000000, 20'h00000, 17'h00000,
              KNOWN, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, COORD_TOP, COORD_BOTTOM, SIDE_MAX, FRAC_MAX,
              KNOWN, 1'b0, 1'b0, 9'd0);
      // The unused code leaves everything alone, even with every field at maximum.
      put_row(OP_UNUSED, COORD_TOP, COORD_TOP, SIDE_MAX, FRAC_MAX,
              KNOWN, 1'b0, 1'b0, 9'd0);
      // These rows add the two extreme corner boxes and one box at the origin.
      put_row(bos_pkg::OP_ADD, COORD_TOP, COORD_TOP, SIDE_MAX, 17'h00000,
              KNOWN, 1'b0, 1'b0, 9'd1);
      put_row(bos_pkg::OP_ADD, COORD_BOTTOM, COORD_BOTTOM, SIDE_MAX, FRAC_MAX,
              KNOWN, 1'b0, 1'b0, 9'd2);
      put_row(bos_pkg::OP_ADD, 24'h000000, 24'h000000, 20'h01000, 17'h00000,
              KNOWN, 1'b0, 1'b0, 9'd3);
      // These queries lie inside the origin box, with fractions of zero, one
      // and above one.
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'h000000, 24'h000000, 20'h00800, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, 24'h000000, 24'h000000, 20'h00800, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, 24'h000000, 24'h000000, 20'h00800, FRAC_ONE,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, 24'h000000, 24'h000000, 20'h00800, FRAC_MAX,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      // These are zero-sized query boxes at the origin.
      put_row(bos_pkg::OP_SIGNIFICANT, 24'h000000, 24'h000000, 20'h00000, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'h000000, 24'h000000, 20'h00000, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      // This query's right edge just touches the left edge of the origin box.
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'hFFF000, 24'h000000, 20'h01000, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      // This query lies in empty space between the stored boxes.
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'h400000, 24'h400000, 20'h00001, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, COORD_TOP, COORD_TOP, SIDE_MAX, FRAC_MAX,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_ANY_OVERLAP, COORD_BOTTOM, COORD_BOTTOM, 20'h00000, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(bos_pkg::OP_SIGNIFICANT, COORD_BOTTOM, COORD_TOP, SIDE_MAX, 17'h08000,
              PREDICTED, 1'b0, 1'b0, 9'd0);
      put_row(OP_UNUSED, 24'h000000, 24'h000000, 20'h00000, 17'h00000,
              KNOWN, 1'b0, 1'b0, 9'd3);
      // This row adds a point box, and the next query is a point on top of it.
      put_row(bos_pkg::OP_ADD, 24'h000001, 24'hFFFFFF, 20'h00000, 17'h0FFFF,
              KNOWN, 1'b0, 1'b0, 9'd4);
      put_row(bos_pkg::OP_ANY_OVERLAP, 24'h000001, 24'hFFFFFF, 20'h00000, 17'h00000,
              PREDICTED, 1'b0, 1'b0, 9'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         offer_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].reply);

      for (int p = 0; p < PHASES; p++) begin
         // The tolerance may only change once the block is idle, that is,
         // once every response that was expected has been taken.
         req_bus.valid <= 1'b0;
         while (expected_replies.size() != 0) @(posedge clock);
         steady_flow = (p == 3 || p == 7);
         csr_write_enable <= 1'b1;
         csr_write_data   <= phase_tolerance[p];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         tolerance_now = phase_tolerance[p];
         // In these phases the response side stops for a long stretch while
         // request words keep coming, so the block backs up onto its input.
         if (p == 2 || p == 6)
            hold_off_request = 1'b1;

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            word.op = ($urandom_range(0, 99) < add_pct[p]) ? bos_pkg::OP_ADD :
                      ($urandom_range(0, 99) < 4) ? OP_UNUSED :
                      ($urandom_range(0, 1) != 0) ? bos_pkg::OP_ANY_OVERLAP :
                      bos_pkg::OP_SIGNIFICANT;
            word.center_x = pick_coord();
            word.center_y = pick_coord();
            roll = $urandom_range(0, 9);
            if (roll < 7)
               word.side = bos_pkg::SIDE_W'($urandom_range(0, 'h3000));
            else if (roll < 9)
               word.side = bos_pkg::SIDE_W'($urandom);
            else
               word.side = ($urandom_range(0, 1) != 0) ? SIDE_MAX : '0;
            roll = $urandom_range(0, 9);
            if (roll < 5)
               word.frac = bos_pkg::FRAC_W'($urandom_range(0, FRAC_ONE));
            else if (roll < 8)
               word.frac = bos_pkg::FRAC_W'($urandom_range(0, FRAC_MAX));
            else if (roll < 9)
               word.frac = ($urandom_range(0, 1) != 0) ? FRAC_MAX : FRAC_ONE;
            else
               word.frac = '0;
            // Words with the unused code are ignored by the block, so they do
            // not count towards the phase.
            if (word.op != OP_UNUSED)
               counted++;
            offer_word(word, PREDICTED, no_reply);
         end
      end

      req_bus.valid <= 1'b0;
      drain = 0;
      while (expected_replies.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      // Wait a little longer, so that any response word the block should not
      // have sent is still caught.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d expected response words never arrived",
                  $time, expected_replies.size());
         failures++;
      end
      if (failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// File: box_overlap_store.f
src/bos_pkg.sv
src/bos_req_if.sv
src/bos_rsp_if.sv
src/bos_ctrl.sv
src/bos_datapath.sv
src/box_overlap_store.sv
sim/testbench.sv
